FILE: src/dda_pkg.sv
// Shared types and codes for the DDA line rasterizer.
// No dependencies; imported by dda_line_rasterizer.
package dda_pkg;

    // Sequencer states, one-hot
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_DIV  = 2'b10
    } dda_state_t;

    // Opcode carried in s_tuser
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

endpackage

FILE: src/dda_line_rasterizer.sv
// DDA line stepper: endpoint load, restoring divider for the minor increment, point output.
// Depends on dda_pkg (state type, opcodes).
//
// Channel | Dir | Handshake          | Payload
// --------+-----+--------------------+------------------------------------------------
// s_*     | in  | s_tvalid/s_tready  | tuser: op; tdata: x_start,y_start,x_end,y_end
// m_*     | out | m_tvalid/m_tready  | tdata: px,py; tlast: last
//
// A step transaction is registered straight into the result. A load transaction also
// runs the subtract-and-compare unit for FRAC_BITS+1 quotient bits, one quotient bit per
// cycle, and no new transaction is taken until the divider is done and the state is idle.
// Lines with zero length skip the divider. The result register frees the input side:
// in idle, a new transaction is taken in the same cycle the held result is taken.
// Reset (rst_n low, asynchronous) clears the sequencer, the line state and the result valid.
module dda_line_rasterizer
    import dda_pkg::*;
#(
    parameter int COORD_BITS = 11,
    parameter int FRAC_BITS  = 16
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // tdata, low bit up: x_start, y_start, x_end, y_end, zero fill to whole bytes
    input  logic [((4*COORD_BITS+7)/8)*8-1:0] s_tdata,
    // tuser: op (0 = load line, 1 = step)
    input  logic                       s_tuser,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // tdata, low bit up: px, py, zero fill to whole bytes
    output logic [((2*COORD_BITS+7)/8)*8-1:0] m_tdata,
    output logic                       m_tlast
);

    localparam int C     = COORD_BITS;
    localparam int P     = COORD_BITS + FRAC_BITS;    // position width, Q(C).(F)
    localparam int CNT_W = COORD_BITS + 1;            // steps remaining
    localparam int QW    = FRAC_BITS + 1;             // quotient bits
    localparam int NW    = COORD_BITS + FRAC_BITS + 2; // rounded dividend width
    localparam int ICW   = $clog2(FRAC_BITS + 1);     // iteration counter width
    localparam int OUT_W = ((2*COORD_BITS+7)/8)*8;
    localparam logic [ICW-1:0] ITER_LAST = ICW'(FRAC_BITS);
    localparam logic [P-1:0]   ONE_POS   = P'(1) << FRAC_BITS;

    // Line state
    dda_state_t        state_reg, state_next;
    logic [P-1:0]      pos_x_reg, pos_x_next;
    logic [P-1:0]      pos_y_reg, pos_y_next;
    logic [P-1:0]      step_x_reg, step_x_next;
    logic [P-1:0]      step_y_reg, step_y_next;
    logic [CNT_W-1:0]  steps_reg, steps_next;
    logic              busy_reg, busy_next;

    // Divider state: partial remainder, dividend bits shifting out / quotient shifting in
    logic [C:0]        rem_reg, rem_next;
    logic [QW-1:0]     shf_reg, shf_next;
    logic [C:0]        dvs_reg, dvs_next;
    logic [ICW-1:0]    iter_reg, iter_next;
    logic              minor_neg_reg, minor_neg_next;
    logic              minor_x_reg, minor_x_next;

    // Result register
    logic              out_valid_reg, out_valid_next;
    logic              last_reg, last_next;

    // Input decode
    logic signed [C-1:0] x1, y1, x2, y2;
    logic signed [C:0]   dx, dy;
    logic [C-1:0]        ax, ay, big, small_d;
    logic                x_major;
    logic [NW-1:0]       num;
    logic [C+1:0]        trial;
    logic [C+1:0]        rem_shift;
    logic [CNT_W-1:0]    steps_dec;
    logic                in_fire;
    logic [C-1:0]        px_pix, py_pix;

    // Truncate a position toward zero, wrapped to C bits
    function automatic logic [C-1:0] to_pixel(input logic [P-1:0] p);
        logic [C-1:0] fl;
        logic         up;
        fl = p[P-1:FRAC_BITS];
        up = p[P-1] & (|p[FRAC_BITS-1:0]);
        return fl + C'(up);
    endfunction

    assign x1 = s_tdata[C-1:0];
    assign y1 = s_tdata[2*C-1:C];
    assign x2 = s_tdata[3*C-1:2*C];
    assign y2 = s_tdata[4*C-1:3*C];
    assign dx = (C+1)'(x2) - (C+1)'(x1);
    assign dy = (C+1)'(y2) - (C+1)'(y1);
    assign ax = dx[C] ? C'(-dx) : dx[C-1:0];
    assign ay = dy[C] ? C'(-dy) : dy[C-1:0];
    // Tie goes to y as the major axis
    assign x_major = ax > ay;
    assign big     = x_major ? ax : ay;
    assign small_d = x_major ? ay : ax;
    // Round to nearest: (m * 2^(F+1) + big) / (2 * big)
    assign num = {1'b0, small_d, {QW{1'b0}}} + NW'(big);

    // Subtract-and-compare unit of the divider
    assign rem_shift = {rem_reg, shf_reg[QW-1]};
    assign trial     = rem_shift - {1'b0, dvs_reg};
    assign steps_dec = steps_reg - CNT_W'(1);

    // Accept when idle and the result slot is free or draining
    assign s_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign in_fire  = s_tvalid && s_tready;

    always_comb
    begin
        state_next     = state_reg;
        pos_x_next     = pos_x_reg;
        pos_y_next     = pos_y_reg;
        step_x_next    = step_x_reg;
        step_y_next    = step_y_reg;
        steps_next     = steps_reg;
        busy_next      = busy_reg;
        rem_next       = rem_reg;
        shf_next       = shf_reg;
        dvs_next       = dvs_reg;
        iter_next      = iter_reg;
        minor_neg_next = minor_neg_reg;
        minor_x_next   = minor_x_reg;
        out_valid_next = out_valid_reg && !m_tready;
        last_next      = last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (s_tuser == OP_LOAD)
                    begin
                        // Start point goes out now; the minor increment follows from the divider
                        pos_x_next     = {x1, {FRAC_BITS{1'b0}}};
                        pos_y_next     = {y1, {FRAC_BITS{1'b0}}};
                        steps_next     = CNT_W'(big);
                        busy_next      = (big != '0);
                        out_valid_next = 1'b1;
                        last_next      = (big == '0);
                        step_x_next    = '0;
                        step_y_next    = '0;
                        if (big != '0)
                        begin
                            if (x_major)
                                step_x_next = dx[C] ? -ONE_POS : ONE_POS;
                            else
                                step_y_next = dy[C] ? -ONE_POS : ONE_POS;
                            minor_x_next   = !x_major;
                            minor_neg_next = x_major ? dy[C] : dx[C];
                            rem_next       = num[NW-1:QW];
                            shf_next       = num[QW-1:0];
                            dvs_next       = {big, 1'b0};
                            iter_next      = '0;
                            state_next     = ST_DIV;
                        end
                    end
                    else if (busy_reg)
                    begin
                        // Advance one step along the line
                        pos_x_next     = pos_x_reg + step_x_reg;
                        pos_y_next     = pos_y_reg + step_y_reg;
                        steps_next     = steps_dec;
                        busy_next      = (steps_dec != '0);
                        out_valid_next = 1'b1;
                        last_next      = (steps_dec == '0);
                    end
                end
            end
            ST_DIV:
            begin
                // One quotient bit per cycle
                if (!trial[C+1])
                begin
                    rem_next = trial[C:0];
                    shf_next = {shf_reg[QW-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_shift[C:0];
                    shf_next = {shf_reg[QW-2:0], 1'b0};
                end
                iter_next = iter_reg + ICW'(1);
                if (iter_reg == ITER_LAST)
                begin
                    state_next = ST_IDLE;
                    if (minor_x_reg)
                        step_x_next = minor_neg_reg ? -P'({shf_next}) : P'({shf_next});
                    else
                        step_y_next = minor_neg_reg ? -P'({shf_next}) : P'({shf_next});
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            step_x_reg    <= '0;
            step_y_reg    <= '0;
            steps_reg     <= '0;
            busy_reg      <= 1'b0;
            iter_reg      <= '0;
            out_valid_reg <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_x_reg     <= pos_x_next;
            pos_y_reg     <= pos_y_next;
            step_x_reg    <= step_x_next;
            step_y_reg    <= step_y_next;
            steps_reg     <= steps_next;
            busy_reg      <= busy_next;
            iter_reg      <= iter_next;
            out_valid_reg <= out_valid_next;
            last_reg      <= last_next;
        end
    end

    // Divider datapath: no reset needed
    always_ff @(posedge clk)
    begin
        rem_reg       <= rem_next;
        shf_reg       <= shf_next;
        dvs_reg       <= dvs_next;
        minor_neg_reg <= minor_neg_next;
        minor_x_reg   <= minor_x_next;
    end

    // Positions change only when a new result is loaded, so the pixel
    // decode holds steady while a result waits.
    assign px_pix   = to_pixel(pos_x_reg);
    assign py_pix   = to_pixel(pos_y_reg);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'({py_pix, px_pix});
    assign m_tlast  = last_reg;

endmodule
